/* rtl/enhanced_link_decoder_arbiter_macros.svh */
// Assertion macros shared by the checker of the enhanced link decoder arbiter.
`ifndef ENHANCED_LINK_DECODER_ARBITER_MACROS_SVH
`define ENHANCED_LINK_DECODER_ARBITER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ELDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elda checker: property violated");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ELDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elda checker: property violated");

`endif

/* rtl/elda_pkg.sv */
// Types, codes and helper functions of the enhanced link decoder arbiter.
package elda_pkg;

    localparam int INFO_MAX_DEF = 16;

    localparam logic [7:0] SYN_SYM = 8'hAA;

    typedef enum logic [1:0] {
        FUNC_RX   = 2'd0,
        FUNC_ARB  = 2'd1,
        FUNC_SEND = 2'd2,
        FUNC_INIT = 2'd3
    } func_t;

    // Commands carried in a received pair.
    localparam logic [3:0] CMD_RESET    = 4'h0;
    localparam logic [3:0] CMD_SYMBOL   = 4'h1;
    localparam logic [3:0] CMD_WON      = 4'h2;
    localparam logic [3:0] CMD_INFO     = 4'h3;
    localparam logic [3:0] CMD_LOST     = 4'hA;
    localparam logic [3:0] CMD_BUS_ERR  = 4'hB;
    localparam logic [3:0] CMD_HOST_ERR = 4'hC;

    // Requests sent to the adapter.
    localparam logic [3:0] TX_INIT  = 4'h0;
    localparam logic [3:0] TX_SEND  = 4'h1;
    localparam logic [3:0] TX_START = 4'h2;
    localparam logic [3:0] TX_INFO  = 4'h3;

    typedef enum logic [2:0] {
        ARB_NONE    = 3'd0,
        ARB_RUNNING = 3'd1,
        ARB_WON     = 3'd2,
        ARB_LOST    = 3'd3,
        ARB_TIMEOUT = 3'd4,
        ARB_ERROR   = 3'd5
    } arb_t;

    typedef enum logic [3:0] {
        EVT_NONE        = 4'd0,
        EVT_RESET       = 4'd1,
        EVT_INFO_LEN    = 4'd2,
        EVT_INFO_BYTE   = 4'd3,
        EVT_BUS_ERROR   = 4'd4,
        EVT_HOST_ERROR  = 4'd5,
        EVT_BAD_CMD     = 4'd6,
        EVT_MISSING_2ND = 4'd7,
        EVT_STRAY_2ND   = 4'd8,
        EVT_ARB_BUSY    = 4'd9,
        EVT_REFUSED     = 4'd10
    } evt_t;

    typedef struct packed {
        logic       pending_valid;
        logic [7:0] pending_byte;
        logic [7:0] master_addr;
        logic [1:0] syn_count;
        logic       reset_pending;
        logic [7:0] info_length;
        logic [7:0] info_count;
    } elda_state_t;

    typedef struct packed {
        logic       sym_valid;
        logic [7:0] sym;
        arb_t       arb_state;
        evt_t       event_res;
        logic [7:0] event_data;
        logic [7:0] info_index;
        logic       info_last;
        logic       tx_valid;
        logic [7:0] tx_first;
        logic [7:0] tx_second;
    } elda_result_t;

    function automatic logic [7:0] pair_first(input logic [3:0] cmd, input logic [7:0] data);
        pair_first = {2'b11, cmd, data[7:6]};
    endfunction

    function automatic logic [7:0] pair_second(input logic [7:0] data);
        pair_second = {2'b10, data[5:0]};
    endfunction

endpackage

/* rtl/elda_core.sv */
// Decode and encode logic of one transaction, with the next value of the link state.
module elda_core
    import elda_pkg::*;
#(
    parameter int INFO_MAX = INFO_MAX_DEF
)
(
    input  logic [1:0]   func,
    input  logic [7:0]   byte_in,
    input  logic         read_only,
    input  elda_state_t  st,
    output elda_state_t  nxt,
    output elda_result_t res
);

    logic [3:0] cmd;
    logic [7:0] data;
    logic       arb_open;
    logic [8:0] info_cnt_inc;

    always_comb
    begin
        cmd          = st.pending_byte[5:2];
        data         = {st.pending_byte[1:0], byte_in[5:0]};
        arb_open     = (st.master_addr != SYN_SYM);
        info_cnt_inc = {1'b0, st.info_count} + 9'd1;
        nxt          = st;
        res          = '0;

        unique case (func_t'(func))
            FUNC_RX:
            begin
                res.arb_state = arb_open ? ARB_RUNNING : ARB_NONE;
                if (st.pending_valid)
                begin
                    nxt.pending_valid = 1'b0;
                    if (byte_in[7:6] == 2'b10)
                    begin
                        unique case (cmd)
                            CMD_WON, CMD_LOST:
                            begin
                                res.sym_valid   = 1'b1;
                                res.sym         = data;
                                res.arb_state   = (cmd == CMD_WON) ? ARB_WON : ARB_LOST;
                                nxt.master_addr = SYN_SYM;
                                nxt.syn_count   = 2'd0;
                            end
                            CMD_SYMBOL:
                            begin
                                res.sym_valid = 1'b1;
                                res.sym       = data;
                                if (data == SYN_SYM && arb_open && st.syn_count != 2'd0)
                                begin
                                    if (st.syn_count != 2'd3)
                                    begin
                                        nxt.syn_count = st.syn_count + 2'd1;
                                    end
                                    else
                                    begin
                                        res.arb_state   = ARB_TIMEOUT;
                                        nxt.master_addr = SYN_SYM;
                                        nxt.syn_count   = 2'd0;
                                    end
                                end
                            end
                            CMD_RESET:
                            begin
                                if (arb_open)
                                begin
                                    res.arb_state   = ARB_ERROR;
                                    nxt.master_addr = SYN_SYM;
                                    nxt.syn_count   = 2'd0;
                                end
                                if (st.reset_pending)
                                begin
                                    nxt.reset_pending = 1'b0;
                                    if (data[0])
                                    begin
                                        res.tx_valid   = 1'b1;
                                        res.tx_first   = pair_first(TX_INFO, 8'h00);
                                        res.tx_second  = pair_second(8'h00);
                                        nxt.info_count = 8'd0;
                                    end
                                end
                                res.event_res  = EVT_RESET;
                                res.event_data = data;
                            end
                            CMD_INFO:
                            begin
                                if (st.info_length == 8'd0)
                                begin
                                    nxt.info_length = data;
                                    nxt.info_count  = 8'd0;
                                    res.event_res   = EVT_INFO_LEN;
                                    res.event_data  = data;
                                end
                                else if (st.info_count < st.info_length
                                         && {1'b0, st.info_count} < 9'(INFO_MAX))
                                begin
                                    res.event_res  = EVT_INFO_BYTE;
                                    res.event_data = data;
                                    res.info_index = st.info_count;
                                    nxt.info_count = info_cnt_inc[7:0];
                                    if (info_cnt_inc >= {1'b0, st.info_length})
                                    begin
                                        res.info_last   = 1'b1;
                                        nxt.info_length = 8'd0;
                                    end
                                end
                                else
                                begin
                                    nxt.info_length = 8'd0;
                                end
                            end
                            CMD_BUS_ERR, CMD_HOST_ERR:
                            begin
                                res.event_res  = (cmd == CMD_BUS_ERR) ? EVT_BUS_ERROR
                                                                      : EVT_HOST_ERROR;
                                res.event_data = data;
                                if (arb_open)
                                begin
                                    res.arb_state   = ARB_ERROR;
                                    nxt.master_addr = SYN_SYM;
                                    nxt.syn_count   = 2'd0;
                                    res.tx_valid    = 1'b1;
                                    res.tx_first    = pair_first(TX_START, SYN_SYM);
                                    res.tx_second   = pair_second(SYN_SYM);
                                end
                            end
                            default:
                            begin
                                res.event_res  = EVT_BAD_CMD;
                                res.event_data = data;
                            end
                        endcase
                    end
                    else
                    begin
                        res.event_res  = EVT_MISSING_2ND;
                        res.event_data = byte_in;
                    end
                end
                else if (!byte_in[7])
                begin
                    res.sym_valid = 1'b1;
                    res.sym       = byte_in;
                end
                else if (!byte_in[6])
                begin
                    res.event_res  = EVT_STRAY_2ND;
                    res.event_data = byte_in;
                end
                else
                begin
                    nxt.pending_valid = 1'b1;
                    nxt.pending_byte  = byte_in;
                end
            end
            FUNC_ARB:
            begin
                if (st.syn_count != 2'd0)
                begin
                    if (byte_in != SYN_SYM)
                    begin
                        res.event_res  = EVT_ARB_BUSY;
                        res.event_data = byte_in;
                    end
                    else
                    begin
                        nxt.master_addr = SYN_SYM;
                        nxt.syn_count   = 2'd0;
                        res.tx_valid    = 1'b1;
                        res.tx_first    = pair_first(TX_START, SYN_SYM);
                        res.tx_second   = pair_second(SYN_SYM);
                    end
                end
                else if (read_only)
                begin
                    res.event_res  = EVT_REFUSED;
                    res.event_data = byte_in;
                end
                else
                begin
                    nxt.master_addr = byte_in;
                    if (byte_in != SYN_SYM)
                    begin
                        res.tx_valid  = 1'b1;
                        res.tx_first  = pair_first(TX_START, byte_in);
                        res.tx_second = pair_second(byte_in);
                        nxt.syn_count = 2'd1;
                    end
                end
            end
            FUNC_SEND:
            begin
                if (read_only)
                begin
                    res.event_res  = EVT_REFUSED;
                    res.event_data = byte_in;
                end
                else
                begin
                    res.tx_valid  = 1'b1;
                    res.tx_first  = pair_first(TX_SEND, byte_in);
                    res.tx_second = pair_second(byte_in);
                end
            end
            FUNC_INIT:
            begin
                nxt.pending_valid = 1'b0;
                nxt.reset_pending = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_first      = pair_first(TX_INIT, 8'h01);
                res.tx_second     = pair_second(8'h01);
            end
            default:
            begin
                nxt = st;
            end
        endcase

        if (func_t'(func) != FUNC_RX)
        begin
            res.arb_state = (nxt.master_addr != SYN_SYM) ? ARB_RUNNING : ARB_NONE;
        end
    end

endmodule

/* rtl/enhanced_link_decoder_arbiter.sv */
// Top level of the enhanced link decoder arbiter: input stage, link state and result register.
// A transaction is held in the input stage, then decoded into the result register,
// from which it is taken while out_ready is high.
// Throughput: one transaction per cycle; a stalled output holds both stages.
// Reset (rst_n low, asynchronous) empties both stages, clears read_only and returns the link
// state to no pending byte and no arbitration open.
module enhanced_link_decoder_arbiter
    import elda_pkg::*;
#(
    parameter int INFO_MAX = INFO_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       sym_valid,
    output logic [7:0] sym,
    output logic [2:0] arb_state,
    output logic [3:0] event_res,
    output logic [7:0] event_data,
    output logic [7:0] info_index,
    output logic       info_last,
    output logic       tx_valid,
    output logic [7:0] tx_first,
    output logic [7:0] tx_second
);

    logic         read_only_reg;
    logic         s1_valid_reg;
    logic [1:0]   s1_func_reg;
    logic [7:0]   s1_byte_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    elda_result_t out_data_reg;
    elda_state_t  state_reg;
    elda_state_t  state_next;
    elda_result_t step_res;
    logic         s1_adv;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    elda_core #(
        .INFO_MAX (INFO_MAX)
    ) u_core (
        .func      (s1_func_reg),
        .byte_in   (s1_byte_reg),
        .read_only (read_only_reg),
        .st        (state_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_comb
    begin
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_only_reg           <= 1'b0;
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.pending_valid <= 1'b0;
            state_reg.pending_byte  <= 8'h00;
            state_reg.master_addr   <= SYN_SYM;
            state_reg.syn_count     <= 2'd0;
            state_reg.reset_pending <= 1'b0;
            state_reg.info_length   <= 8'd0;
            state_reg.info_count    <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                read_only_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg <= func;
            s1_byte_reg <= byte_in;
        end
        if (s1_adv)
        begin
            out_data_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sym_valid  = out_data_reg.sym_valid;
    assign sym        = out_data_reg.sym;
    assign arb_state  = out_data_reg.arb_state;
    assign event_res  = out_data_reg.event_res;
    assign event_data = out_data_reg.event_data;
    assign info_index = out_data_reg.info_index;
    assign info_last  = out_data_reg.info_last;
    assign tx_valid   = out_data_reg.tx_valid;
    assign tx_first   = out_data_reg.tx_first;
    assign tx_second  = out_data_reg.tx_second;

endmodule

/* rtl/elda_checker.sv */
// Port checker of the enhanced link decoder arbiter and its bind to the top level.
`include "enhanced_link_decoder_arbiter_macros.svh"

module elda_checker
    import elda_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       sym_valid,
    input logic [7:0] sym,
    input logic [2:0] arb_state,
    input logic [3:0] event_res,
    input logic [7:0] event_data,
    input logic [7:0] info_index,
    input logic       info_last,
    input logic       tx_valid,
    input logic [7:0] tx_first,
    input logic [7:0] tx_second
);

    // A stalled result transaction keeps its payload until it is taken.
    `ELDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(sym_valid) && $stable(sym) && $stable(arb_state)
        && $stable(event_res) && $stable(event_data) && $stable(info_index)
        && $stable(info_last) && $stable(tx_valid) && $stable(tx_first)
        && $stable(tx_second))

    // With the result register empty the input side is never stalled.
    `ELDA_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

    // Every transmitted pair is a well-formed escape sequence.
    `ELDA_ASSERT_SAME(a_tx_form, out_valid && tx_valid,
        tx_first[7:6] == 2'b11 && tx_second[7:6] == 2'b10)

    // A delivered bus symbol carries no event and no transmission.
    `ELDA_ASSERT_SAME(a_sym_alone, out_valid && sym_valid, event_res == EVT_NONE && !tx_valid)

    // The final-byte flag only accompanies an info byte.
    `ELDA_ASSERT_SAME(a_last_info, out_valid && info_last, event_res == EVT_INFO_BYTE)

endmodule

bind enhanced_link_decoder_arbiter elda_checker u_elda_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench of the enhanced link decoder arbiter: directed and random link traffic.
`timescale 1ns / 1ps

module tb_top;
    import elda_pkg::*;

    localparam int          INFO_LIMIT    = INFO_MAX_DEF;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          DRAIN_TAIL    = 4;
    localparam logic [3:0]  CMD_UNUSED    = 4'h4;
    localparam logic [3:0]  CMD_UNUSED_HI = 4'hF;
    localparam logic [7:0]  INIT_DATA     = 8'h01;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = FUNC_RX;
    logic [7:0] byte_in = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       sym_valid;
    logic [7:0] sym;
    logic [2:0] arb_state;
    logic [3:0] event_res;
    logic [7:0] event_data;
    logic [7:0] info_index;
    logic       info_last;
    logic       tx_valid;
    logic [7:0] tx_first;
    logic [7:0] tx_second;

    // Predicted link state.
    logic       held_first_valid = 1'b0;
    logic [7:0] held_first = 8'h00;
    logic [7:0] arb_master = SYN_SYM;
    logic [1:0] syn_seen = 2'd0;
    logic [7:0] features = 8'h00;
    logic       init_pending = 1'b0;
    logic [7:0] info_len = 8'h00;
    logic [7:0] info_seen = 8'h00;
    logic       ro_mode = 1'b0;

    elda_result_t link_results_q[$];

    int  next_gap = 1;
    bit  no_idle = 1'b0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  outcomes_seen = 0;
    int  pairs_sent_seen = 0;
    int  errors = 0;
    int  stall_cycles = 0;

    enhanced_link_decoder_arbiter #(
        .INFO_MAX(INFO_LIMIT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sym_valid  (sym_valid),
        .sym        (sym),
        .arb_state  (arb_state),
        .event_res  (event_res),
        .event_data (event_data),
        .info_index (info_index),
        .info_last  (info_last),
        .tx_valid   (tx_valid),
        .tx_first   (tx_first),
        .tx_second  (tx_second)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void close_arbitration();
        arb_master = SYN_SYM;
        syn_seen = 2'd0;
    endfunction

    function automatic void load_tx(inout elda_result_t r, input logic [3:0] c,
                                    input logic [7:0] d);
        r.tx_valid  = 1'b1;
        r.tx_first  = 8'hC0 | {2'b00, c, 2'b00} | {6'd0, d[7:6]};
        r.tx_second = 8'h80 | {2'b00, d[5:0]};
    endfunction

    function automatic elda_result_t decode_link_item(input func_t f, input logic [7:0] b);
        elda_result_t r;
        logic [3:0]   cmd;
        logic [7:0]   d;
        r = '0;
        if (f == FUNC_RX)
        begin
            r.arb_state = (arb_master != SYN_SYM) ? ARB_RUNNING : ARB_NONE;
            if (held_first_valid)
            begin
                held_first_valid = 1'b0;
                if (b[7:6] != 2'b10)
                begin
                    r.event_res  = EVT_MISSING_2ND;
                    r.event_data = b;
                end
                else
                begin
                    cmd = held_first[5:2];
                    d   = {held_first[1:0], b[5:0]};
                    case (cmd)
                        CMD_WON, CMD_LOST:
                        begin
                            r.sym_valid = 1'b1;
                            r.sym       = d;
                            r.arb_state = (cmd == CMD_WON) ? ARB_WON : ARB_LOST;
                            close_arbitration();
                        end
                        CMD_SYMBOL:
                        begin
                            r.sym_valid = 1'b1;
                            r.sym       = d;
                            if (d == SYN_SYM && r.arb_state == ARB_RUNNING && syn_seen != 0)
                            begin
                                if (syn_seen < 3)
                                    syn_seen++;
                                else
                                begin
                                    r.arb_state = ARB_TIMEOUT;
                                    close_arbitration();
                                end
                            end
                        end
                        CMD_RESET:
                        begin
                            if (r.arb_state != ARB_NONE)
                            begin
                                r.arb_state = ARB_ERROR;
                                close_arbitration();
                            end
                            features = d;
                            if (init_pending)
                            begin
                                init_pending = 1'b0;
                                if (d[0])
                                begin
                                    load_tx(r, TX_INFO, 8'h00);
                                    info_seen = 8'h00;
                                end
                            end
                            r.event_res  = EVT_RESET;
                            r.event_data = d;
                        end
                        CMD_INFO:
                        begin
                            if (info_len == 0)
                            begin
                                info_len     = d;
                                info_seen    = 8'h00;
                                r.event_res  = EVT_INFO_LEN;
                                r.event_data = d;
                            end
                            else if (info_seen < info_len && info_seen < INFO_LIMIT)
                            begin
                                r.event_res  = EVT_INFO_BYTE;
                                r.event_data = d;
                                r.info_index = info_seen;
                                info_seen++;
                                if (info_seen >= info_len)
                                begin
                                    r.info_last = 1'b1;
                                    info_len    = 8'h00;
                                end
                            end
                            else
                                info_len = 8'h00;
                        end
                        CMD_BUS_ERR, CMD_HOST_ERR:
                        begin
                            r.event_res  = (cmd == CMD_BUS_ERR) ? EVT_BUS_ERROR : EVT_HOST_ERROR;
                            r.event_data = d;
                            if (arb_master != SYN_SYM)
                            begin
                                r.arb_state = ARB_ERROR;
                                close_arbitration();
                                load_tx(r, TX_START, SYN_SYM);
                            end
                        end
                        default:
                        begin
                            r.event_res  = EVT_BAD_CMD;
                            r.event_data = d;
                        end
                    endcase
                end
            end
            else if (!b[7])
            begin
                r.sym_valid = 1'b1;
                r.sym       = b;
            end
            else if (b[7:6] == 2'b10)
            begin
                r.event_res  = EVT_STRAY_2ND;
                r.event_data = b;
            end
            else
            begin
                held_first_valid = 1'b1;
                held_first       = b;
            end
            return r;
        end
        if (f == FUNC_ARB)
        begin
            if (syn_seen != 0)
            begin
                if (b != SYN_SYM)
                begin
                    r.event_res  = EVT_ARB_BUSY;
                    r.event_data = b;
                end
                else
                begin
                    close_arbitration();
                    load_tx(r, TX_START, SYN_SYM);
                end
            end
            else if (ro_mode)
            begin
                r.event_res  = EVT_REFUSED;
                r.event_data = b;
            end
            else
            begin
                arb_master = b;
                if (b != SYN_SYM)
                begin
                    load_tx(r, TX_START, b);
                    syn_seen = 2'd1;
                end
            end
        end
        else if (f == FUNC_SEND)
        begin
            if (ro_mode)
            begin
                r.event_res  = EVT_REFUSED;
                r.event_data = b;
            end
            else
                load_tx(r, TX_SEND, b);
        end
        else
        begin
            features         = 8'h00;
            held_first_valid = 1'b0;
            load_tx(r, TX_INIT, INIT_DATA);
            init_pending     = 1'b1;
        end
        r.arb_state = (arb_master != SYN_SYM) ? ARB_RUNNING : ARB_NONE;
        return r;
    endfunction

    task automatic send_item(input func_t f, input logic [7:0] b);
        elda_result_t r;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        func     <= f;
        byte_in  <= b;
        do @(posedge clk); while (!in_ready);
        r = decode_link_item(f, b);
        link_results_q.push_back(r);
        items_sent++;
        if (r.arb_state >= ARB_WON)
            outcomes_seen++;
        if (r.tx_valid)
            pairs_sent_seen++;
        next_gap = draw_gap();
        if (next_gap != 0)
            in_valid <= 1'b0;
    endtask

    task automatic send_pair(input logic [3:0] cmd, input logic [7:0] d);
        send_item(FUNC_RX, {2'b11, cmd, d[7:6]});
        send_item(FUNC_RX, {2'b10, d[5:0]});
    endtask

    task automatic wait_link_idle();
        if (next_gap == 0)
        begin
            in_valid <= 1'b0;
            next_gap = 1;
        end
        while (link_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_read_only(input logic v);
        wait_link_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ro_mode = v;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin : result_checker
        elda_result_t exp_r;
        int           gap;
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
                out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (link_results_q.size() == 0)
            begin
                $error("result transaction arrived with no expectation waiting");
                errors++;
            end
            else
            begin
                exp_r = link_results_q.pop_front();
                results_checked++;
                check_field("sym_valid", exp_r.sym_valid, sym_valid);
                check_field("sym", exp_r.sym, sym);
                check_field("arb_state", exp_r.arb_state, arb_state);
                check_field("event_res", exp_r.event_res, event_res);
                check_field("event_data", exp_r.event_data, event_data);
                check_field("info_index", exp_r.info_index, info_index);
                check_field("info_last", exp_r.info_last, info_last);
                check_field("tx_valid", exp_r.tx_valid, tx_valid);
                check_field("tx_first", exp_r.tx_first, tx_first);
                check_field("tx_second", exp_r.tx_second, tx_second);
            end
        end
    end

    function automatic logic [3:0] random_cmd();
        case ($urandom_range(0, 9))
            0, 1:    return CMD_SYMBOL;
            2:       return CMD_WON;
            3:       return CMD_LOST;
            4:       return CMD_RESET;
            5:       return CMD_INFO;
            6:       return CMD_BUS_ERR;
            7:       return CMD_HOST_ERR;
            default: return 4'($urandom);
        endcase
    endfunction

    task automatic test_plain_bytes();
        send_item(FUNC_RX, 8'h00);
        send_item(FUNC_RX, 8'h7F);
    endtask

    task automatic test_framing_errors();
        send_item(FUNC_RX, 8'h80);
        send_item(FUNC_RX, 8'hFF);
        send_item(FUNC_RX, {2'b11, CMD_UNUSED, 2'b00});
        send_pair(CMD_UNUSED_HI, 8'hFF);
    endtask

    task automatic test_syn_timeout();
        int k;
        send_item(FUNC_ARB, 8'hFF);
        for (k = 0; k < 4; k++)
            send_pair(CMD_SYMBOL, SYN_SYM);
    endtask

    task automatic test_arbitration_requests();
        send_item(FUNC_ARB, 8'h01);
        send_item(FUNC_ARB, 8'h00);
        send_item(FUNC_ARB, SYN_SYM);
    endtask

    task automatic test_init_sequence();
        send_item(FUNC_INIT, 8'h00);
        send_pair(CMD_RESET, 8'h01);
        send_item(FUNC_SEND, 8'hFF);
    endtask

    task automatic test_read_only();
        write_read_only(1'b1);
        send_item(FUNC_SEND, 8'h00);
        send_item(FUNC_ARB, 8'h55);
        write_read_only(1'b0);
    endtask

    task automatic run_random_scenario();
        int         sel;
        int         n;
        int         k;
        logic [7:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            send_item(FUNC_RX, 8'($urandom_range(0, 127)));
        else if (sel < 34)
            send_pair(random_cmd(), ($urandom_range(0, 3) == 0) ? SYN_SYM : 8'($urandom));
        else if (sel < 50)
        begin
            v = ($urandom_range(0, 9) == 0) ? SYN_SYM : 8'($urandom);
            send_item(FUNC_ARB, v);
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
                send_pair(CMD_SYMBOL, ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYN_SYM);
            case ($urandom_range(0, 7))
                0:       send_pair(CMD_WON, v);
                1:       send_pair(CMD_LOST, 8'($urandom));
                2:       send_pair(CMD_BUS_ERR, 8'($urandom));
                3:       send_pair(CMD_HOST_ERR, 8'($urandom));
                4:       send_pair(CMD_RESET, 8'($urandom));
                5:       send_item(FUNC_ARB, 8'($urandom));
                6:       send_item(FUNC_ARB, SYN_SYM);
                default: ;
            endcase
        end
        else if (sel < 60)
        begin
            v = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            send_pair(CMD_INFO, v);
            n = ((v > 20) ? 20 : int'(v)) + (($urandom_range(0, 3) == 0) ? 2 : 0);
            for (k = 0; k < n; k++)
                send_pair(CMD_INFO, 8'($urandom));
        end
        else if (sel < 70)
            send_item(FUNC_SEND, 8'($urandom));
        else if (sel < 77)
        begin
            send_item(FUNC_INIT, 8'($urandom));
            if ($urandom_range(0, 3) != 0)
                send_pair(CMD_RESET, 8'($urandom));
        end
        else if (sel < 86)
            send_item(FUNC_ARB, ($urandom_range(0, 2) == 0) ? SYN_SYM : 8'($urandom));
        else if (sel < 93)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                send_item(FUNC_RX, 8'($urandom));
        end
        else
        begin
            send_item(FUNC_RX, 8'($urandom_range(8'hC0, 8'hFF)));
            send_item(FUNC_RX, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                          : 8'($urandom_range(8'hC0, 8'hFF)));
        end
    endtask

    task automatic run_random_phase(input logic ro, input bit steady, input int count);
        int goal;
        write_read_only(ro);
        no_idle = steady;
        goal = items_sent + count;
        while (items_sent < goal)
            run_random_scenario();
        wait_link_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b0, 1'b0, 600);
        run_random_phase(1'b1, 1'b0, 300);
        run_random_phase(1'b0, 1'b1, 300);
        run_random_phase(1'b0, 1'b0, 500);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_framing_errors();
        test_syn_timeout();
        test_arbitration_requests();
        test_init_sequence();
        test_read_only();
        test_random_traffic();
        wait_link_idle();
        $display("Sent %0d link transactions and checked %0d results, in both read-only modes.",
                 items_sent, results_checked);
        $display("Arbitration outcomes predicted: %0d; transmit pairs predicted: %0d.",
                 outcomes_seen, pairs_sent_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
